// ===== hdl/vhd_pkg.sv =====
// ----------------------------------------------------------------------------
// vhd_pkg: shared types and constants for the vector heading block
// widths, angle constants, arctangent steps and the cordic cell payload
// ----------------------------------------------------------------------------
package vhd_pkg;

   // input components and cordic length
   localparam int IN_WIDTH    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int MAX_STEPS   = 24;
   localparam int STEP_IDX_W  = $clog2(MAX_STEPS);
   localparam int PRESCALE    = 24;

   // working widths: magnitude, prescale, and headroom for cordic gain
   localparam int XW = IN_WIDTH + 1 + PRESCALE + 3;
   localparam int ZW = 25;
   localparam int AW = 25;

   // bus widths
   localparam int REQ_DATA_W = 2 * IN_WIDTH;
   localparam int HEAD_W     = 16;
   localparam int OFF_W      = 9;

   // angle constants in 2^-16 degree
   localparam int Z_ONE_DEG = 65536;
   localparam logic [AW-1:0] Q90  = AW'(90 * Z_ONE_DEG);
   localparam logic [AW-1:0] Q180 = AW'(180 * Z_ONE_DEG);
   localparam logic [AW-1:0] Q360 = AW'(360 * Z_ONE_DEG);

   // output scale: 1/128 degree
   localparam logic [HEAD_W:0]   FULL_TURN_OUT = (HEAD_W + 1)'(46080);
   localparam logic [AW-1:0]     ROUND_HALF    = AW'(256);
   localparam int                ROUND_SHIFT   = 9;
   localparam logic [OFF_W-1:0]  FULL_DEG      = OFF_W'(360);
   localparam logic [OFF_W-1:0]  OFFSET_RESET  = OFF_W'(135);

   // cordic cell payload
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } vec_type;

   // side info that rides along the chain
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic zero_vec;
      logic x_zero;
      logic y_zero;
   } tag_type;

   // round(atan(2^-i) in degrees * 65536)
   function automatic logic [ZW-1:0] atan_step(input logic [STEP_IDX_W-1:0] idx);
      logic [ZW-1:0] val;
      case (idx)
         5'd0:    val = ZW'(2949120);
         5'd1:    val = ZW'(1740967);
         5'd2:    val = ZW'(919879);
         5'd3:    val = ZW'(466945);
         5'd4:    val = ZW'(234379);
         5'd5:    val = ZW'(117304);
         5'd6:    val = ZW'(58666);
         5'd7:    val = ZW'(29335);
         5'd8:    val = ZW'(14668);
         5'd9:    val = ZW'(7334);
         5'd10:   val = ZW'(3667);
         5'd11:   val = ZW'(1833);
         5'd12:   val = ZW'(917);
         5'd13:   val = ZW'(458);
         5'd14:   val = ZW'(229);
         5'd15:   val = ZW'(115);
         5'd16:   val = ZW'(57);
         5'd17:   val = ZW'(29);
         5'd18:   val = ZW'(14);
         5'd19:   val = ZW'(7);
         5'd20:   val = ZW'(4);
         5'd21:   val = ZW'(2);
         5'd22:   val = ZW'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/vector_heading_degrees_top.sv =====
// ----------------------------------------------------------------------------
// vector_heading_degrees_top: full-circle heading of a direction vector
// pipelined cordic atan2 in 1/128 degree with a texture offset wrap
// ----------------------------------------------------------------------------
// usage
//   req_* carries one direction vector per item (dir_x, dir_y, signed q8.8,
//   y positive downward). rsp_* returns the heading in 1/128 degree, 0 to
//   46079, minus texture_offset whole degrees modulo 360, and a zero-vector
//   flag in rsp_tuser (heading then 0).
//   csr_wr_en writes texture_offset from csr_wr_data; values above 359 are
//   reduced modulo 360 on the write. write it only while the block is idle.
// timing
//   one item per cycle sustained while rsp_tready is high. an accepted item
//   passes twenty registers in line on its way to rsp_tvalid: the input
//   stage, 16 cordic cells, fold and round stages, and the output register.
//   the cell chain sets the latency.
// reset
//   synchronous, active high; empties the pipeline and sets the offset to
//   135 degrees.
// stall
//   when rsp_tready is low the output register holds its item and one more
//   item lands in a skid register; req_tready then drops and the whole chain
//   freezes until the skid register drains. req_tready is a register output.
// ----------------------------------------------------------------------------
module vector_heading_degrees_top (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [vhd_pkg::OFF_W-1:0]         csr_wr_data,  // texture_offset
   // input channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [vhd_pkg::REQ_DATA_W-1:0]    req_tdata,    // dir_x, dir_y
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [vhd_pkg::HEAD_W-1:0]        rsp_tdata,    // heading
   output logic [0:0]                        rsp_tuser     // zero_vector
);

   localparam int N = vhd_pkg::CORDIC_STEPS;

   // offset register, kept already reduced modulo 360
   logic [vhd_pkg::OFF_W-1:0] off_ff;
   logic [vhd_pkg::OFF_W-1:0] off_in;

   // global pipeline advance: the chain moves while the skid slot is free
   logic advance;

   // input stage
   logic signed [vhd_pkg::IN_WIDTH-1:0] dir_x;
   logic signed [vhd_pkg::IN_WIDTH-1:0] dir_y;
   logic [vhd_pkg::IN_WIDTH:0]          ax;
   logic [vhd_pkg::IN_WIDTH:0]          ay;
   vhd_pkg::vec_type                    vec_in;
   vhd_pkg::tag_type                    tag_in;

   // chain links, index 0 is the input stage register
   logic             chain_valid [N+1];
   vhd_pkg::vec_type chain_vec   [N+1];
   vhd_pkg::tag_type chain_tag   [N+1];

   logic             in_valid_ff;
   vhd_pkg::vec_type in_vec_ff;
   vhd_pkg::tag_type in_tag_ff;

   // tail of the pipeline
   logic                        tail_valid;
   logic [vhd_pkg::HEAD_W-1:0]  tail_head;
   logic                        tail_zero;

   // output register and skid slot
   logic                        out_valid_ff;
   logic [vhd_pkg::HEAD_W-1:0]  out_head_ff;
   logic                        out_zero_ff;
   logic                        skid_valid_ff;
   logic [vhd_pkg::HEAD_W-1:0]  skid_head_ff;
   logic                        skid_zero_ff;
   logic                        out_free;

   // offset write with modulo-360 reduction
   assign off_in = (csr_wr_data >= vhd_pkg::FULL_DEG) ?
                   csr_wr_data - vhd_pkg::FULL_DEG : csr_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= vhd_pkg::OFFSET_RESET;
      end else if (csr_wr_en) begin
         off_ff <= off_in;
      end
   end

   assign advance    = !skid_valid_ff;
   assign req_tready = advance;

   // unpack, take magnitudes, prescale into the working width
   always_comb begin
      dir_x = req_tdata[vhd_pkg::IN_WIDTH-1:0];
      dir_y = req_tdata[2*vhd_pkg::IN_WIDTH-1:vhd_pkg::IN_WIDTH];
      ax = dir_x[vhd_pkg::IN_WIDTH-1] ? -{dir_x[vhd_pkg::IN_WIDTH-1], dir_x}
                                      :  {dir_x[vhd_pkg::IN_WIDTH-1], dir_x};
      ay = dir_y[vhd_pkg::IN_WIDTH-1] ? -{dir_y[vhd_pkg::IN_WIDTH-1], dir_y}
                                      :  {dir_y[vhd_pkg::IN_WIDTH-1], dir_y};
      vec_in.x = {{(vhd_pkg::XW-vhd_pkg::IN_WIDTH-1-vhd_pkg::PRESCALE){1'b0}},
                  ax, {vhd_pkg::PRESCALE{1'b0}}};
      vec_in.y = {{(vhd_pkg::XW-vhd_pkg::IN_WIDTH-1-vhd_pkg::PRESCALE){1'b0}},
                  ay, {vhd_pkg::PRESCALE{1'b0}}};
      vec_in.z = '0;
      tag_in.neg_x    = dir_x[vhd_pkg::IN_WIDTH-1];
      tag_in.neg_y    = dir_y[vhd_pkg::IN_WIDTH-1];
      tag_in.x_zero   = (dir_x == '0);
      tag_in.y_zero   = (dir_y == '0);
      tag_in.zero_vec = (dir_x == '0) && (dir_y == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_vec_ff <= vec_in;
         in_tag_ff <= tag_in;
      end
   end

   assign chain_valid[0] = in_valid_ff;
   assign chain_vec[0]   = in_vec_ff;
   assign chain_tag[0]   = in_tag_ff;

   // one cell per cordic rotation
   for (genvar k = 0; k < N; k++) begin : g_cell
      vhd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .step_index (vhd_pkg::STEP_IDX_W'(k)),
         .valid_in   (chain_valid[k]),
         .vec_in     (chain_vec[k]),
         .tag_in     (chain_tag[k]),
         .valid_out  (chain_valid[k+1]),
         .vec_out    (chain_vec[k+1]),
         .tag_out    (chain_tag[k+1])
      );
   end

   vhd_post u_post (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .offset      (off_ff),
      .valid_in    (chain_valid[N]),
      .vec_in      (chain_vec[N]),
      .tag_in      (chain_tag[N]),
      .valid_out   (tail_valid),
      .heading     (tail_head),
      .zero_vector (tail_zero)
   );

   // output register with one skid slot behind it
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= tail_valid;
         end
      end else if (advance && tail_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_head_ff <= skid_head_ff;
            out_zero_ff <= skid_zero_ff;
         end else begin
            out_head_ff <= tail_head;
            out_zero_ff <= tail_zero;
         end
      end else if (advance && tail_valid) begin
         skid_head_ff <= tail_head;
         skid_zero_ff <= tail_zero;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_head_ff;
   assign rsp_tuser[0] = out_zero_ff;

   // the skid slot only fills behind a held output item
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot holds an item while the output register is empty");

   // the skid slot fills only on a stalled output
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid slot filled without a stall");

   // a zero vector always reports heading zero
   a_zero_heading: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("zero vector with nonzero heading");

   // heading stays below a full turn
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata < vhd_pkg::HEAD_W'(vhd_pkg::FULL_TURN_OUT)))
      else $error("heading at or above a full turn");

   // stored offset is always reduced below 360
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      off_ff < vhd_pkg::FULL_DEG)
      else $error("texture offset not reduced");

endmodule

// ===== hdl/vhd_cell.sv =====
// ----------------------------------------------------------------------------
// vhd_cell: one cordic vectoring rotation
// rotates (x, y) toward the x axis by atan(2^-i) and registers the result
// ----------------------------------------------------------------------------
module vhd_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [vhd_pkg::STEP_IDX_W-1:0]    step_index,
   input  logic                              valid_in,
   input  vhd_pkg::vec_type                  vec_in,
   input  vhd_pkg::tag_type                  tag_in,
   output logic                              valid_out,
   output vhd_pkg::vec_type                  vec_out,
   output vhd_pkg::tag_type                  tag_out
);

   logic                      valid_ff;
   vhd_pkg::vec_type          vec_ff;
   vhd_pkg::vec_type          vec_in_nx;
   vhd_pkg::tag_type          tag_ff;
   logic signed [vhd_pkg::XW-1:0] dx;
   logic signed [vhd_pkg::XW-1:0] dy;
   logic signed [vhd_pkg::ZW-1:0] dz;

   // floor shifts of the partner coordinate
   always_comb begin
      dx = vec_in.y >>> step_index;
      dy = vec_in.x >>> step_index;
      dz = $signed(vhd_pkg::atan_step(step_index));
      if (!vec_in.y[vhd_pkg::XW-1]) begin
         vec_in_nx.x = vec_in.x + dx;
         vec_in_nx.y = vec_in.y - dy;
         vec_in_nx.z = vec_in.z + dz;
      end else begin
         vec_in_nx.x = vec_in.x - dx;
         vec_in_nx.y = vec_in.y + dy;
         vec_in_nx.z = vec_in.z - dz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in_nx;
         tag_ff <= tag_in;
      end
   end

   assign valid_out = valid_ff;
   assign vec_out   = vec_ff;
   assign tag_out   = tag_ff;

endmodule

// ===== hdl/vhd_post.sv =====
// ----------------------------------------------------------------------------
// vhd_post: quadrant fold, rounding and offset wrap
// two stages: clamp and fold to full circle, then round to 1/128 degree
// ----------------------------------------------------------------------------
module vhd_post (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [vhd_pkg::OFF_W-1:0]         offset,
   input  logic                              valid_in,
   input  vhd_pkg::vec_type                  vec_in,
   input  vhd_pkg::tag_type                  tag_in,
   output logic                              valid_out,
   output logic [vhd_pkg::HEAD_W-1:0]        heading,
   output logic                              zero_vector
);

   logic                          fold_valid_ff;
   logic [vhd_pkg::AW-1:0]        angle_ff;
   logic [vhd_pkg::AW-1:0]        angle_in;
   logic                          fold_zero_ff;
   logic [vhd_pkg::AW-1:0]        zc;

   logic                          out_valid_ff;
   logic [vhd_pkg::HEAD_W-1:0]    head_ff;
   logic [vhd_pkg::HEAD_W-1:0]    head_in;
   logic                          zero_ff;

   logic [vhd_pkg::AW:0]          rounded;
   logic [vhd_pkg::HEAD_W:0]      h_raw;
   logic [vhd_pkg::HEAD_W-1:0]    h_wrap;
   logic [vhd_pkg::HEAD_W-1:0]    off_scaled;

   // stage 1: clamp to [0, 90] with axis overrides, then fold by signs
   always_comb begin
      if (tag_in.y_zero || vec_in.z[vhd_pkg::ZW-1]) begin
         zc = '0;
      end else if (tag_in.x_zero ||
                   vhd_pkg::AW'(unsigned'(vec_in.z)) > vhd_pkg::Q90) begin
         zc = vhd_pkg::Q90;
      end else begin
         zc = vhd_pkg::AW'(unsigned'(vec_in.z));
      end
      case ({tag_in.neg_x, tag_in.neg_y})
         2'b00:   angle_in = zc;
         2'b10:   angle_in = vhd_pkg::Q180 - zc;
         2'b11:   angle_in = vhd_pkg::Q180 + zc;
         2'b01:   angle_in = vhd_pkg::Q360 - zc;
         default: angle_in = zc;
      endcase
   end

   // stage 2: round, wrap the full turn, subtract offset modulo full turn
   always_comb begin
      rounded    = {1'b0, angle_ff} + {1'b0, vhd_pkg::ROUND_HALF};
      h_raw      = rounded[vhd_pkg::AW:vhd_pkg::ROUND_SHIFT];
      h_wrap     = (h_raw >= vhd_pkg::FULL_TURN_OUT) ?
                   vhd_pkg::HEAD_W'(h_raw - vhd_pkg::FULL_TURN_OUT) :
                   vhd_pkg::HEAD_W'(h_raw);
      off_scaled = {offset, 7'b0};
      if (fold_zero_ff) begin
         head_in = '0;
      end else if (h_wrap < off_scaled) begin
         head_in = h_wrap + vhd_pkg::HEAD_W'(vhd_pkg::FULL_TURN_OUT) - off_scaled;
      end else begin
         head_in = h_wrap - off_scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         fold_valid_ff <= valid_in;
         out_valid_ff  <= fold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff     <= angle_in;
         fold_zero_ff <= tag_in.zero_vec;
         head_ff      <= head_in;
         zero_ff      <= fold_zero_ff;
      end
   end

   assign valid_out   = out_valid_ff;
   assign heading     = head_ff;
   assign zero_vector = zero_ff;

endmodule
